/* design/crc_checked_frame_deframer_assert.svh */
// Assertion macros shared by the deframer RTL.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CRCDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CRCDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/crcdf_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// crcdf_pkg
// Shared types, constants and the CRC-32C byte update of the deframer.
// ---------------------------------------------------------------------------
package crcdf_pkg;

    localparam int LEN_BITS = 24;
    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [4:0]  HDR_LAST = 5'd27;
    localparam logic [4:0]  HDR_CRC_SPAN = 5'd20;
    localparam logic [7:0]  MAGIC [4] = '{8'h46, 8'h43, 8'h52, 8'h46};
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic [1:0] CFG_VERSION = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN = 2'd1;

    localparam logic [1:0] RK_HEADER = 2'd0;
    localparam logic [1:0] RK_PAYLOAD = 2'd1;
    localparam logic [1:0] RK_END = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_MAGIC = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_HDR_CRC = 3'd3;
    localparam logic [2:0] ST_LIMIT = 3'd4;
    localparam logic [2:0] ST_PAY_CRC = 3'd5;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    typedef enum logic [2:0] {
        OP_HDR,
        OP_HDR_END,
        OP_PAY,
        OP_PAY_END,
        OP_END
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [7:0]          data;
        logic [2:0]          status;
        logic [15:0]         kind;
        logic [63:0]         corr;
        logic [LEN_BITS-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic [15:0]         frame_kind;
        logic [63:0]         correlation_id;
        logic [LEN_BITS-1:0] frame_length;
        logic [7:0]          payload_byte;
        logic [2:0]          status;
        logic                last;
    } t_res;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage
`default_nettype wire

/* design/crcdf_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// crcdf interfaces
// Byte input, result output and register write channels.
// ---------------------------------------------------------------------------
interface crcdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface crcdf_out_if import crcdf_pkg::*;;
    logic                valid;
    logic                ready;
    logic [1:0]          result_kind;
    logic [15:0]         frame_kind;
    logic [63:0]         correlation_id;
    logic [LEN_BITS-1:0] frame_length;
    logic [7:0]          payload_byte;
    logic [2:0]          status;
    logic                last;
    modport source (output valid, output result_kind, output frame_kind,
                    output correlation_id, output frame_length, output payload_byte,
                    output status, output last, input ready);
    modport sink (input valid, input result_kind, input frame_kind,
                  input correlation_id, input frame_length, input payload_byte,
                  input status, input last, output ready);
endinterface

interface crcdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/crc_checked_frame_deframer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// crc_checked_frame_deframer
// Deframer for length-prefixed frames with CRC-32C header and payload checks.
// ---------------------------------------------------------------------------
// Usage: stream bytes enter on i_in, one per transfer. Results leave on
// o_out: a header result per accepted frame, a payload result per data byte,
// and an end result (last high) carrying ok, a header fault or a payload CRC
// mismatch. Registers are written on i_cfg (index 0 expected version, index 1
// payload length limit); the user must write them only while the block is
// idle, which the block does not enforce; i_cfg is always ready. Throughput
// is one byte per cycle while the queue is not full, set by the byte-wide CRC
// update in the parser. Bytes that give two results (empty payload, last
// payload byte) fill the output register twice, which the queue absorbs. The
// first result of a transfer passes the queue and the output register before
// o_out shows it. When the receiver stalls, the four-entry queue fills and
// i_in.ready falls. Reset clears the parser to header byte 0, empties the
// queue and restores the register defaults (version 1, limit 65536).
// ---------------------------------------------------------------------------
`include "crc_checked_frame_deframer_assert.svh"
module crc_checked_frame_deframer import crcdf_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    crcdf_in_if.sink     i_in,
    crcdf_cfg_if.sink    i_cfg,
    crcdf_out_if.source  o_out
);

    logic   push;
    logic   pop;
    t_cmd   cmd;
    t_cmd   head;
    t_qstat qstat;
    logic   is_end;

    assign is_end = (o_out.result_kind == RK_END);

    crcdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    crcdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    crcdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    `CRCDF_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, push, !qstat.full)
    `CRCDF_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, pop, !qstat.empty)
    `CRCDF_ASSERT_NOW(a_last_is_end, i_clk, i_rst_n, o_out.valid, (o_out.last == is_end))

endmodule
`default_nettype wire

/* design/crcdf_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// crcdf_front
// Header parser and payload tracker; turns each payload byte and each completed header into a queue command.
// ---------------------------------------------------------------------------
module crcdf_front import crcdf_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    crcdf_in_if.sink    i_in,
    crcdf_cfg_if.sink   i_cfg,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_phase              r_phase, n_phase;
    logic [4:0]          r_pos, n_pos;
    logic                r_magic, n_magic;
    logic [15:0]         r_version, n_version;
    logic [15:0]         r_kind, n_kind;
    logic [31:0]         r_len, n_len;
    logic [63:0]         r_corr, n_corr;
    logic [31:0]         r_hcrc, n_hcrc;
    logic [31:0]         r_pcrc, n_pcrc;
    logic [31:0]         r_crc, n_crc;
    logic [LEN_BITS-1:0] r_rem, n_rem;
    logic [15:0]         r_exp_ver;
    logic [23:0]         r_max;
    logic                accept;
    logic [7:0]          b;
    logic [31:0]         crc_base;
    logic [31:0]         limit;

    assign i_in.ready = !i_qstat.full;
    assign i_cfg.ready = 1'b1;
    assign accept = i_in.valid && i_in.ready;
    assign b = i_in.stream_byte;
    assign limit = ({8'd0, r_max} > LEN_MASK) ? LEN_MASK : {8'd0, r_max};

    always_comb begin
        n_phase = r_phase;
        n_pos = r_pos;
        n_magic = r_magic;
        n_version = r_version;
        n_kind = r_kind;
        n_len = r_len;
        n_corr = r_corr;
        n_hcrc = r_hcrc;
        n_pcrc = r_pcrc;
        n_crc = r_crc;
        n_rem = r_rem;
        o_push = 1'b0;
        o_cmd = '0;
        o_cmd.op = OP_END;
        o_cmd.data = b;
        crc_base = (r_pos == 5'd0) ? CRC_INIT : r_crc;
        case (r_phase)
            PH_PAYLOAD: begin
                n_crc = crc32c_byte(r_crc, b);
                n_rem = r_rem - 1'b1;
                o_push = accept;
                if (n_rem == '0) begin
                    o_cmd.op = OP_PAY_END;
                    o_cmd.status = (~n_crc == r_pcrc) ? ST_OK : ST_PAY_CRC;
                    n_phase = PH_HEADER;
                    n_pos = 5'd0;
                    n_magic = 1'b1;
                    n_crc = CRC_INIT;
                end else begin
                    o_cmd.op = OP_PAY;
                end
            end
            default: begin
                n_magic = (r_pos == 5'd0) ? 1'b1 : r_magic;
                if (r_pos < 5'd4 && b != MAGIC[r_pos[1:0]]) begin
                    n_magic = 1'b0;
                end
                n_crc = (r_pos < HDR_CRC_SPAN) ? crc32c_byte(crc_base, b) : crc_base;
                if (r_pos inside {[5'd4:5'd5]}) begin
                    n_version = {b, r_version[15:8]};
                end else if (r_pos inside {[5'd6:5'd7]}) begin
                    n_kind = {b, r_kind[15:8]};
                end else if (r_pos inside {[5'd8:5'd11]}) begin
                    n_len = {b, r_len[31:8]};
                end else if (r_pos inside {[5'd12:5'd19]}) begin
                    n_corr = {b, r_corr[63:8]};
                end else if (r_pos inside {[5'd20:5'd23]}) begin
                    n_hcrc = {b, r_hcrc[31:8]};
                end else if (r_pos inside {[5'd24:5'd27]}) begin
                    n_pcrc = {b, r_pcrc[31:8]};
                end
                n_phase = PH_HEADER;
                if (r_pos < HDR_LAST) begin
                    n_pos = r_pos + 1'b1;
                end else begin
                    o_push = accept;
                    n_pos = 5'd0;
                    n_magic = 1'b1;
                    n_crc = CRC_INIT;
                    o_cmd.kind = r_kind;
                    o_cmd.corr = r_corr;
                    o_cmd.len = r_len[LEN_BITS-1:0];
                    if (!r_magic) begin
                        o_cmd.status = ST_MAGIC;
                    end else if (r_version != r_exp_ver) begin
                        o_cmd.status = ST_VERSION;
                    end else if (r_hcrc != ~r_crc) begin
                        o_cmd.status = ST_HDR_CRC;
                    end else if (r_len > limit) begin
                        o_cmd.status = ST_LIMIT;
                    end else if (r_len == 32'd0) begin
                        o_cmd.op = OP_HDR_END;
                        o_cmd.status = (n_pcrc == 32'd0) ? ST_OK : ST_PAY_CRC;
                    end else begin
                        o_cmd.op = OP_HDR;
                        n_phase = PH_PAYLOAD;
                        n_rem = r_len[LEN_BITS-1:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos <= 5'd0;
            r_magic <= 1'b1;
            r_crc <= CRC_INIT;
            r_rem <= '0;
            r_exp_ver <= 16'd1;
            r_max <= 24'd65536;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_pos <= n_pos;
                r_magic <= n_magic;
                r_crc <= n_crc;
                r_rem <= n_rem;
            end
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_VERSION) begin
                    r_exp_ver <= i_cfg.data[15:0];
                end else if (i_cfg.index == CFG_MAX_LEN) begin
                    r_max <= i_cfg.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_version <= n_version;
            r_kind <= n_kind;
            r_len <= n_len;
            r_corr <= n_corr;
            r_hcrc <= n_hcrc;
            r_pcrc <= n_pcrc;
        end
    end

endmodule
`default_nettype wire

/* design/crcdf_queue.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// crcdf_queue
// Short command queue between the parser and the result emitter.
// ---------------------------------------------------------------------------
module crcdf_queue import crcdf_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_push,
    input  t_cmd    i_cmd,
    input  wire     i_pop,
    output t_cmd    o_head,
    output t_qstat  o_stat
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_head = r_mem[r_rd];
    assign o_stat.full = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

/* design/crcdf_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// crcdf_back
// Expands queue commands into one or two results in an output register.
// ---------------------------------------------------------------------------
module crcdf_back import crcdf_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_head,
    input  t_qstat       i_qstat,
    output logic         o_pop,
    crcdf_out_if.source  o_out
);

    logic  r_valid;
    logic  r_second;
    t_res  r_res, n_res;
    logic  load;
    logic  dbl;
    logic  take;

    assign load = !r_valid || o_out.ready;
    assign dbl = (i_head.op == OP_HDR_END) || (i_head.op == OP_PAY_END);
    assign take = load && !i_qstat.empty;
    assign o_pop = take && (!dbl || r_second);

    always_comb begin
        n_res = '0;
        case (i_head.op)
            OP_HDR, OP_HDR_END: begin
                if (r_second) begin
                    n_res.result_kind = RK_END;
                    n_res.status = i_head.status;
                    n_res.last = 1'b1;
                end else begin
                    n_res.result_kind = RK_HEADER;
                    n_res.frame_kind = i_head.kind;
                    n_res.correlation_id = i_head.corr;
                    n_res.frame_length = i_head.len;
                end
            end
            OP_PAY, OP_PAY_END: begin
                if (r_second) begin
                    n_res.result_kind = RK_END;
                    n_res.status = i_head.status;
                    n_res.last = 1'b1;
                end else begin
                    n_res.result_kind = RK_PAYLOAD;
                    n_res.payload_byte = i_head.data;
                end
            end
            default: begin
                n_res.result_kind = RK_END;
                n_res.status = i_head.status;
                n_res.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= !i_qstat.empty;
            if (take) begin
                r_second <= dbl && !r_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.result_kind = r_res.result_kind;
    assign o_out.frame_kind = r_res.frame_kind;
    assign o_out.correlation_id = r_res.correlation_id;
    assign o_out.frame_length = r_res.frame_length;
    assign o_out.payload_byte = r_res.payload_byte;
    assign o_out.status = r_res.status;
    assign o_out.last = r_res.last;

endmodule
`default_nettype wire

/* verif/tb_crc_checked_frame_deframer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tb_crc_checked_frame_deframer
// Self-checking testbench for the CRC-32C frame deframer. A behavioural
// predictor builds the expected header, payload and end results for every
// byte transfer; a checker compares each output transfer with them in order.
// Directed frames cover every header fault, empty and one-byte payloads and
// the register extremes; random frames follow, with random stalls.
// ---------------------------------------------------------------------------
module tb_crc_checked_frame_deframer import crcdf_pkg::*;;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    crcdf_in_if  in_ch ();
    crcdf_cfg_if cfg_ch ();
    crcdf_out_if out_ch ();

    crc_checked_frame_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("crc_checked_frame_deframer: mismatch");
            $finish;
        end
    end

    // Predictor state and register copies.
    logic [15:0] version_reg;
    logic [23:0] limit_reg;
    logic        in_payload;
    logic [4:0]  hdr_pos;
    logic        magic_ok;
    logic [15:0] version_got;
    logic [15:0] kind_got;
    logic [31:0] length_got;
    logic [63:0] corr_got;
    logic [31:0] hdr_crc_got;
    logic [31:0] pay_crc_got;
    logic [31:0] crc_acc;
    logic [23:0] bytes_left;

    t_res expected_results[$];

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 32'h82F63B78) : (x >> 1);
        return x;
    endfunction

    function automatic t_res end_result(input logic [2:0] st);
        t_res r;
        r = '0;
        r.result_kind = RK_END;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic restart_parser();
        in_payload = 1'b0;
        hdr_pos = 5'd0;
        magic_ok = 1'b1;
        crc_acc = 32'hFFFFFFFF;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        t_res r;
        logic [4:0] p;
        p = hdr_pos;
        if (in_payload) begin
            r = '0;
            r.result_kind = RK_PAYLOAD;
            r.payload_byte = b;
            expected_results.push_back(r);
            crc_acc = crc_step(crc_acc, b);
            bytes_left = bytes_left - 24'd1;
            if (bytes_left == 0) begin
                expected_results.push_back(end_result((~crc_acc == pay_crc_got) ? ST_OK
                                                                                 : ST_PAY_CRC));
                restart_parser();
            end
            return;
        end
        if (p == 0) begin
            magic_ok = 1'b1;
            crc_acc = 32'hFFFFFFFF;
        end
        if (p < 4 && b != MAGIC[p[1:0]]) magic_ok = 1'b0;
        if (p < 20) crc_acc = crc_step(crc_acc, b);
        if (p >= 4 && p < 6) version_got = {b, version_got[15:8]};
        else if (p >= 6 && p < 8) kind_got = {b, kind_got[15:8]};
        else if (p >= 8 && p < 12) length_got = {b, length_got[31:8]};
        else if (p >= 12 && p < 20) corr_got = {b, corr_got[63:8]};
        else if (p >= 20 && p < 24) hdr_crc_got = {b, hdr_crc_got[31:8]};
        else if (p >= 24) pay_crc_got = {b, pay_crc_got[31:8]};
        if (p < 27) begin
            hdr_pos = p + 5'd1;
            return;
        end
        if (!magic_ok) expected_results.push_back(end_result(ST_MAGIC));
        else if (version_got != version_reg) expected_results.push_back(end_result(ST_VERSION));
        else if (hdr_crc_got != ~crc_acc) expected_results.push_back(end_result(ST_HDR_CRC));
        else if (length_got > {8'd0, limit_reg}) expected_results.push_back(end_result(ST_LIMIT));
        else begin
            r = '0;
            r.result_kind = RK_HEADER;
            r.frame_kind = kind_got;
            r.correlation_id = corr_got;
            r.frame_length = length_got[23:0];
            expected_results.push_back(r);
            restart_parser();
            if (length_got == 0) begin
                expected_results.push_back(end_result((pay_crc_got == 0) ? ST_OK : ST_PAY_CRC));
            end else begin
                bytes_left = length_got[23:0];
                in_payload = 1'b1;
            end
            return;
        end
        restart_parser();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error: %s got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Result checker with random back-pressure.
    int unsigned stall_left = 0;
    initial out_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result kind", out_ch.result_kind, 0);
            end else begin
                want = expected_results.pop_front();
                if (out_ch.result_kind !== want.result_kind)
                    report_mismatch("result_kind", out_ch.result_kind, want.result_kind);
                if (out_ch.frame_kind !== want.frame_kind)
                    report_mismatch("frame_kind", out_ch.frame_kind, want.frame_kind);
                if (out_ch.correlation_id !== want.correlation_id)
                    report_mismatch("correlation_id", out_ch.correlation_id,
                                    want.correlation_id);
                if (out_ch.frame_length !== want.frame_length)
                    report_mismatch("frame_length", out_ch.frame_length,
                                    want.frame_length);
                if (out_ch.payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", out_ch.payload_byte, want.payload_byte);
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
                if (out_ch.last !== want.last)
                    report_mismatch("last", out_ch.last, want.last);
            end
        end
        // A fresh wait is drawn after each transfer; a quarter of the time none.
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (out_ch.valid && out_ch.ready) begin
            if ($urandom_range(3) == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                stall_left <= $urandom_range(15);
                out_ch.ready <= 1'b0;
            end
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    logic burst_mode = 1'b0;

    // Valid stays high after a transfer unless a gap follows, so that one time
    // step never sees it both dropped and raised.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(15);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.stream_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_byte(b);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_VERSION) version_reg = value[15:0];
        else limit_reg = value;
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Builds and sends one frame; fault selects which header field is spoilt.
    // The payload is sent only when the header is meant to be accepted.
    task automatic send_frame(input logic [2:0] fault, input logic [31:0] len,
                              input logic spoil_payload);
        logic [7:0] hdr[28];
        logic [7:0] body[$];
        logic [31:0] c;
        logic [15:0] ver;
        logic [15:0] knd;
        logic [63:0] corr;
        ver = (fault == ST_VERSION) ? version_reg + 16'd1 : version_reg;
        knd = 16'($urandom);
        corr = {$urandom, $urandom};
        hdr[0] = 8'h46; hdr[1] = 8'h43; hdr[2] = 8'h52; hdr[3] = 8'h46;
        if (fault == ST_MAGIC) hdr[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        hdr[4] = ver[7:0]; hdr[5] = ver[15:8];
        hdr[6] = knd[7:0]; hdr[7] = knd[15:8];
        for (int i = 0; i < 4; i++) hdr[8 + i] = len[8*i +: 8];
        for (int i = 0; i < 8; i++) hdr[12 + i] = corr[8*i +: 8];
        c = 32'hFFFFFFFF;
        for (int i = 0; i < 20; i++) c = crc_step(c, hdr[i]);
        c = ~c;
        if (fault == ST_HDR_CRC) c ^= 32'(1) << $urandom_range(31);
        for (int i = 0; i < 4; i++) hdr[20 + i] = c[8*i +: 8];
        body = {};
        c = 32'hFFFFFFFF;
        if (fault == ST_OK && len <= {8'd0, limit_reg}) begin
            for (int i = 0; i < len; i++) begin
                body.push_back(8'($urandom));
                c = crc_step(c, body[i]);
            end
        end
        c = ~c;
        if (spoil_payload) c ^= 32'(1) << $urandom_range(31);
        for (int i = 0; i < 4; i++) hdr[24 + i] = c[8*i +: 8];
        foreach (hdr[i]) send_byte(hdr[i]);
        foreach (body[i]) send_byte(body[i]);
    endtask

    task automatic test_reset_defaults();
        send_frame(ST_OK, 32'd3, 1'b0);
        send_frame(ST_OK, 32'd0, 1'b0);
        send_frame(ST_OK, 32'd0, 1'b1);
        drain();
    endtask

    task automatic test_header_faults();
        send_frame(ST_MAGIC, 32'd2, 1'b0);
        send_frame(ST_VERSION, 32'd2, 1'b0);
        send_frame(ST_HDR_CRC, 32'd2, 1'b0);
        send_frame(ST_OK, 32'd65537, 1'b0);
        send_frame(ST_OK, 32'h0100_0000, 1'b0);
        send_frame(ST_OK, 32'd1, 1'b1);
        drain();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_VERSION, 24'h00FFFF);
        write_register(CFG_MAX_LEN, 24'd0);
        send_frame(ST_OK, 32'd0, 1'b0);
        send_frame(ST_OK, 32'd1, 1'b0);
        drain();
        write_register(CFG_VERSION, 24'd0);
        write_register(CFG_MAX_LEN, 24'hFFFFFF);
        send_frame(ST_OK, 32'd2, 1'b0);
        send_frame(ST_OK, 32'hFF00_0001, 1'b0);
        send_frame(ST_VERSION, 32'd1, 1'b0);
        drain();
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned pick;
        sent = 0;
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            write_register(CFG_VERSION, 24'($urandom));
            write_register(CFG_MAX_LEN, 24'($urandom_range(40, 4)));
            burst_mode = (phase_no == 2);
            for (int n = 0; n < 3; n++) begin
                pick = $urandom_range(15);
                if (pick < 10)
                    send_frame(ST_OK, $urandom_range(limit_reg), $urandom_range(3) == 0);
                else if (pick == 10) send_frame(ST_MAGIC, 32'd1, 1'b0);
                else if (pick == 11) send_frame(ST_VERSION, 32'd1, 1'b0);
                else if (pick == 12) send_frame(ST_HDR_CRC, 32'd1, 1'b0);
                else if (pick == 13) send_frame(ST_OK, {$urandom} | 32'd64, 1'b0);
                else for (int k = 0; k < 28; k++) send_byte(8'($urandom));
                sent++;
                if (sent > 0 && $urandom_range(15) == 0) drain();
            end
            drain();
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.stream_byte = 8'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_VERSION;
        cfg_ch.data = 24'd0;
        version_reg = 16'd1;
        limit_reg = 24'd65536;
        version_got = '0; kind_got = '0; length_got = '0; corr_got = '0;
        hdr_crc_got = '0; pay_crc_got = '0; bytes_left = '0;
        restart_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_header_faults();
        test_register_extremes();
        test_random_frames();
        drain();
        if (error_count == 0) begin
            $display("crc_checked_frame_deframer: match");
        end else begin
            $display("crc_checked_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+design
design/crcdf_pkg.sv
design/crcdf_if.sv
design/crcdf_front.sv
design/crcdf_queue.sv
design/crcdf_back.sv
design/crc_checked_frame_deframer.sv
verif/tb_crc_checked_frame_deframer.sv
